[hw/rtl/pfmas_pkg.sv]
// shared types and constants for the prime-field modular add/subtract block
package pfmas_pkg;

  // datapath word and modulus widths
  localparam int WORD_W = 32;
  localparam int CFG_W  = 64;
  localparam int NUM_CFG = 4;
  localparam int CFG_IDX_W = 2;
  localparam int MOD_W  = CFG_W * NUM_CFG;

  // operation codes
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  // running comparison of raw sum against modulus
  localparam logic [1:0] CMP_EQUAL   = 2'd0;
  localparam logic [1:0] CMP_GREATER = 2'd1;
  localparam logic [1:0] CMP_LESS    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOD_W0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_W1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_W2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_W3 = 2'd3;

  // modulus reset value (p-256 prime)
  localparam logic [CFG_W-1:0] MOD_W0_RST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [CFG_W-1:0] MOD_W1_RST = 64'h0000_0000_FFFF_FFFF;
  localparam logic [CFG_W-1:0] MOD_W2_RST = 64'h0000_0000_0000_0000;
  localparam logic [CFG_W-1:0] MOD_W3_RST = 64'hFFFF_FFFF_0000_0001;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // one classified word pair
  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } item_t;

  // queue status seen by the back end
  typedef struct packed {
    logic  avail;
    item_t item;
  } q_head_t;

endpackage

[hw/rtl/pfmas_front.sv]
// front end: accepts word pairs, latches the operation per block
module pfmas_front #(
  parameter int NUM_WORDS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       req_type,
  input  logic [pfmas_pkg::WORD_W-1:0] x_word,
  input  logic [pfmas_pkg::WORD_W-1:0] y_word,
  input  logic                       q_full,
  output logic                       push,
  output pfmas_pkg::item_t           push_item
);

  localparam int IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [IDX_W-1:0] word_count;
  logic             op_latch;
  logic             first_word;
  logic             op_cur;

  // operation is taken from the first word of a block only
  assign first_word = (word_count == '0);
  assign op_cur     = first_word ? req_type : op_latch;

  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;

  always_comb begin
    push_item.op = op_cur;
    push_item.x  = x_word;
    push_item.y  = y_word;
  end

  // word counter and op latch
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
      op_latch   <= pfmas_pkg::OP_ADD;
    end else if (push) begin
      op_latch <= op_cur;
      if (word_count == IDX_W'(NUM_WORDS - 1)) begin
        word_count <= '0;
      end else begin
        word_count <= word_count + 1'b1;
      end
    end
  end

endmodule

[hw/rtl/pfmas_queue.sv]
// two-entry item queue between front and back
module pfmas_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pfmas_pkg::item_t    push_item,
  output logic                full,
  input  logic                pop,
  output pfmas_pkg::q_head_t  head
);

  pfmas_pkg::item_t                 mem [pfmas_pkg::Q_DEPTH];
  logic [pfmas_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [pfmas_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [pfmas_pkg::Q_CNT_W-1:0]    count;

  assign full       = (count == pfmas_pkg::Q_CNT_W'(pfmas_pkg::Q_DEPTH));
  assign head.avail = (count != '0);
  assign head.item  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + pfmas_pkg::Q_CNT_W'(push) - pfmas_pkg::Q_CNT_W'(pop);
    end
  end

endmodule

[hw/rtl/pfmas_back.sv]
// back end: word-serial add/sub, then conditional modulus correction and output
module pfmas_back #(
  parameter int NUM_WORDS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pfmas_pkg::MOD_W-1:0]   modulus,
  input  pfmas_pkg::q_head_t            head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfmas_pkg::WORD_W-1:0]  r_word,
  output logic                          last_word
);

  localparam int IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int W     = pfmas_pkg::WORD_W;

  localparam logic ST_ACCUM   = 1'b0;
  localparam logic ST_CORRECT = 1'b1;

  logic             state;
  logic [IDX_W-1:0] word_count;
  logic [IDX_W-1:0] cor_idx;
  logic             carry_borrow;
  logic [1:0]       compare_status;
  logic             op;
  logic             fix;
  logic             cor_cb;
  logic [W-1:0]     partial_words [NUM_WORDS];

  logic [W-1:0]     m_acc;
  logic [W:0]       acc_t;
  logic [W-1:0]     acc_w;
  logic             acc_cb;
  logic [1:0]       cmp_next;
  logic             acc_last;
  logic             fix_next;

  logic [W-1:0]     m_cor;
  logic [W-1:0]     raw;
  logic [W:0]       cor_t;
  logic [W-1:0]     cor_w;
  logic             out_load;
  logic             cor_last;

  // accumulate one word pair
  assign pop   = (state == ST_ACCUM) & head.avail;
  assign m_acc = modulus[W*word_count +: W];

  always_comb begin
    if (head.item.op == pfmas_pkg::OP_ADD) begin
      acc_t = {1'b0, head.item.x} + {1'b0, head.item.y} + {{W{1'b0}}, carry_borrow};
    end else begin
      acc_t = {1'b0, head.item.x} - {1'b0, head.item.y} - {{W{1'b0}}, carry_borrow};
    end
    acc_w  = acc_t[W-1:0];
    acc_cb = acc_t[W];
    cmp_next = compare_status;
    if (head.item.op == pfmas_pkg::OP_ADD) begin
      if (acc_w > m_acc) begin
        cmp_next = pfmas_pkg::CMP_GREATER;
      end else if (acc_w < m_acc) begin
        cmp_next = pfmas_pkg::CMP_LESS;
      end
    end
    acc_last = (word_count == IDX_W'(NUM_WORDS - 1));
    if (head.item.op == pfmas_pkg::OP_ADD) begin
      fix_next = acc_cb | (cmp_next != pfmas_pkg::CMP_LESS);
    end else begin
      fix_next = acc_cb;
    end
  end

  // correction of one stored word
  assign m_cor    = modulus[W*cor_idx +: W];
  assign raw      = partial_words[cor_idx];
  assign out_load = (state == ST_CORRECT) & (~out_valid | ~out_stall);
  assign cor_last = (cor_idx == IDX_W'(NUM_WORDS - 1));

  always_comb begin
    if (op == pfmas_pkg::OP_ADD) begin
      cor_t = {1'b0, raw} - {1'b0, m_cor} - {{W{1'b0}}, cor_cb};
    end else begin
      cor_t = {1'b0, raw} + {1'b0, m_cor} + {{W{1'b0}}, cor_cb};
    end
    cor_w = fix ? cor_t[W-1:0] : raw;
  end

  // partial word store
  always_ff @(posedge clk) begin
    if (pop) begin
      partial_words[word_count] <= acc_w;
    end
  end

  // control and running status
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_ACCUM;
      word_count     <= '0;
      cor_idx        <= '0;
      carry_borrow   <= 1'b0;
      compare_status <= pfmas_pkg::CMP_EQUAL;
      op             <= pfmas_pkg::OP_ADD;
      fix            <= 1'b0;
      cor_cb         <= 1'b0;
    end else begin
      case (state)
        ST_ACCUM: begin
          if (pop) begin
            if (acc_last) begin
              state          <= ST_CORRECT;
              word_count     <= '0;
              carry_borrow   <= 1'b0;
              compare_status <= pfmas_pkg::CMP_EQUAL;
              op             <= head.item.op;
              fix            <= fix_next;
              cor_idx        <= '0;
              cor_cb         <= 1'b0;
            end else begin
              word_count     <= word_count + 1'b1;
              carry_borrow   <= acc_cb;
              compare_status <= cmp_next;
            end
          end
        end
        ST_CORRECT: begin
          if (out_load) begin
            cor_cb <= cor_t[W];
            if (cor_last) begin
              state   <= ST_ACCUM;
              cor_idx <= '0;
            end else begin
              cor_idx <= cor_idx + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_ACCUM;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      r_word    <= cor_w;
      last_word <= cor_last;
    end
  end

endmodule

[hw/rtl/prime_field_mod_add_sub.sv]
// top level of the prime-field modular add/subtract block
// Usage: operands enter on the input channel as 32-bit word pairs (x_word,
// y_word), least significant first, NUM_WORDS items per operation; req_type
// on the first item selects add (0) or subtract (1). The front end counts
// words and latches the operation, a two-entry queue decouples it from the back
// end, which, while an item is queued and it is not correcting, adds or
// subtracts one word per cycle with a running carry and (add only) a running
// compare against the modulus. After the last word the back end emits NUM_WORDS
// corrected words, one per cycle while out_stall is low, on the output channel;
// last_word marks the most significant one. out_valid rises once the last item
// has passed the queue, the accumulate step and the output register. Throughput
// is set by the back end, which runs the accumulate pass, then the correction
// pass, one word per cycle each unless stalled; it pops no items in correction.
// The receiver may hold out_stall at any time; the output register keeps its
// item and the queue fills, after which in_stall rises.
// The modulus is four 64-bit registers written over the cfg channel (always
// ready); reset loads the p-256 prime and clears all word counters.
module prime_field_mod_add_sub #(
  parameter int NUM_WORDS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [pfmas_pkg::WORD_W-1:0]      x_word,
  input  logic [pfmas_pkg::WORD_W-1:0]      y_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pfmas_pkg::WORD_W-1:0]      r_word,
  output logic                              last_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pfmas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfmas_pkg::CFG_W-1:0]       cfg_data
);

  logic [pfmas_pkg::CFG_W-1:0] modulus_w0;
  logic [pfmas_pkg::CFG_W-1:0] modulus_w1;
  logic [pfmas_pkg::CFG_W-1:0] modulus_w2;
  logic [pfmas_pkg::CFG_W-1:0] modulus_w3;
  logic [pfmas_pkg::MOD_W-1:0] modulus;

  logic                        q_full;
  logic                        push;
  pfmas_pkg::item_t            push_item;
  logic                        pop;
  pfmas_pkg::q_head_t          head;

  // modulus registers
  assign cfg_ready = 1'b1;
  assign modulus   = {modulus_w3, modulus_w2, modulus_w1, modulus_w0};

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_w0 <= pfmas_pkg::MOD_W0_RST;
      modulus_w1 <= pfmas_pkg::MOD_W1_RST;
      modulus_w2 <= pfmas_pkg::MOD_W2_RST;
      modulus_w3 <= pfmas_pkg::MOD_W3_RST;
    end else if (cfg_valid & cfg_ready) begin
      case (cfg_index)
        pfmas_pkg::REG_MOD_W0: modulus_w0 <= cfg_data;
        pfmas_pkg::REG_MOD_W1: modulus_w1 <= cfg_data;
        pfmas_pkg::REG_MOD_W2: modulus_w2 <= cfg_data;
        pfmas_pkg::REG_MOD_W3: modulus_w3 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front end
  pfmas_front #(
    .NUM_WORDS (NUM_WORDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .x_word    (x_word),
    .y_word    (y_word),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // item queue
  pfmas_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  // back end
  pfmas_back #(
    .NUM_WORDS (NUM_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .modulus   (modulus),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .r_word    (r_word),
    .last_word (last_word)
  );

endmodule

[sim/tb.sv]
// testbench for prime_field_mod_add_sub: directed and random multiword operations
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS     = 8;
  localparam int WIDE      = pfmas_pkg::WORD_W * WORDS;
  localparam int LONG_HOLD = 150;
  localparam int SETTLE    = 20;
  localparam int NUM_PHASES = 7;
  localparam int OPS_PER_PHASE = 4;
  localparam logic [WIDE-1:0] P256 = {pfmas_pkg::MOD_W3_RST, pfmas_pkg::MOD_W2_RST,
                                      pfmas_pkg::MOD_W1_RST, pfmas_pkg::MOD_W0_RST};
  localparam logic [WIDE-1:0] ALL_ONES = '1;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic                            req_type;
  logic [pfmas_pkg::WORD_W-1:0]    x_word;
  logic [pfmas_pkg::WORD_W-1:0]    y_word;
  logic                            out_valid;
  logic                            out_stall;
  logic [pfmas_pkg::WORD_W-1:0]    r_word;
  logic                            last_word;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [pfmas_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pfmas_pkg::CFG_W-1:0]     cfg_data;

  prime_field_mod_add_sub #(.NUM_WORDS(WORDS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .x_word(x_word), .y_word(y_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .r_word(r_word), .last_word(last_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // one expected result word
  typedef struct {
    logic [pfmas_pkg::WORD_W-1:0] value;
    logic                         is_last;
  } sum_word_t;

  // one directed operation
  typedef struct {
    logic            op;
    logic [WIDE-1:0] x;
    logic [WIDE-1:0] y;
    bit              typed;
    logic [WIDE-1:0] sum;
    bit              flip;
  } op_row_t;

  sum_word_t expected_words[$];
  int        errors;
  int        words_checked;
  int        add_ops;
  int        sub_ops;
  int        settings_used;
  bit        src_calm;
  bit        sink_calm;
  int        hold_asks;
  int        src_gap;
  bit        src_hold;

  // predictor state
  logic [pfmas_pkg::CFG_W-1:0]  mod_reg [pfmas_pkg::NUM_CFG];
  logic [pfmas_pkg::WORD_W-1:0] raw_words [WORDS];
  logic [pfmas_pkg::WORD_W-1:0] fixed_words [WORDS];
  logic                         carry_run;
  logic [1:0]                   cmp_run;
  int                           word_pos;
  logic                         op_held;

  function automatic logic [pfmas_pkg::WORD_W-1:0] modulus_word(int i);
    logic [pfmas_pkg::CFG_W-1:0] r;
    r = mod_reg[i / 2];
    return (i % 2) ? r[63:32] : r[31:0];
  endfunction

  function automatic logic [WIDE-1:0] modulus_now();
    return {mod_reg[pfmas_pkg::REG_MOD_W3], mod_reg[pfmas_pkg::REG_MOD_W2],
            mod_reg[pfmas_pkg::REG_MOD_W1], mod_reg[pfmas_pkg::REG_MOD_W0]};
  endfunction

  // accumulate one word pair; returns 1 and fills fixed_words on the last word
  function automatic bit addsub_word(logic op, logic [pfmas_pkg::WORD_W-1:0] x,
                                     logic [pfmas_pkg::WORD_W-1:0] y);
    logic [pfmas_pkg::WORD_W:0]   t;
    logic [pfmas_pkg::WORD_W-1:0] w;
    logic [pfmas_pkg::WORD_W-1:0] m;
    logic                         fix;
    logic                         cb;
    int                           idx;
    idx = word_pos;
    m = modulus_word(idx);
    if (idx == 0) op_held = op;
    if (op_held == pfmas_pkg::OP_ADD) begin
      t = {1'b0, x} + {1'b0, y} + carry_run;
      w = t[pfmas_pkg::WORD_W-1:0];
      carry_run = t[pfmas_pkg::WORD_W];
      if (w > m) cmp_run = pfmas_pkg::CMP_GREATER;
      else if (w < m) cmp_run = pfmas_pkg::CMP_LESS;
    end else begin
      t = {1'b0, x} - {1'b0, y} - carry_run;
      w = t[pfmas_pkg::WORD_W-1:0];
      carry_run = t[pfmas_pkg::WORD_W];
    end
    raw_words[idx] = w;
    if (idx + 1 < WORDS) begin
      word_pos = idx + 1;
      return 1'b0;
    end
    // single conditional correction, carry out dropped
    if (op_held == pfmas_pkg::OP_ADD) fix = carry_run || (cmp_run != pfmas_pkg::CMP_LESS);
    else fix = carry_run;
    cb = 1'b0;
    for (int i = 0; i < WORDS; i++) begin
      w = raw_words[i];
      if (fix) begin
        if (op_held == pfmas_pkg::OP_ADD) t = {1'b0, w} - {1'b0, modulus_word(i)} - cb;
        else t = {1'b0, w} + {1'b0, modulus_word(i)} + cb;
        cb = t[pfmas_pkg::WORD_W];
        w = t[pfmas_pkg::WORD_W-1:0];
      end
      fixed_words[i] = w;
    end
    carry_run = 1'b0;
    cmp_run = pfmas_pkg::CMP_EQUAL;
    word_pos = 0;
    return 1'b1;
  endfunction

  // random wide value, optionally built from all-zero and all-one words
  function automatic logic [WIDE-1:0] random_wide(bit edgy);
    logic [WIDE-1:0] v;
    for (int i = 0; i < WORDS; i++) begin
      case (edgy ? $urandom_range(0, 2) : 2)
        0: v[pfmas_pkg::WORD_W*i +: pfmas_pkg::WORD_W] = '0;
        1: v[pfmas_pkg::WORD_W*i +: pfmas_pkg::WORD_W] = '1;
        default: v[pfmas_pkg::WORD_W*i +: pfmas_pkg::WORD_W] = $urandom;
      endcase
    end
    return v;
  endfunction

  // mostly reduced operands, some unreduced or at the top of the field
  function automatic logic [WIDE-1:0] pick_operand(logic [WIDE-1:0] m);
    logic [WIDE-1:0] v;
    int              kind;
    kind = $urandom_range(0, 9);
    v = random_wide(kind >= 8);
    if (kind == 9 && m != '0) v = m - 1'b1;
    else if (kind < 7 && m != '0) v = v % m;
    return v;
  endfunction

  // compare one result item with the oldest expectation
  task automatic check_word(logic [pfmas_pkg::WORD_W-1:0] got, logic got_last);
    sum_word_t e;
    if (expected_words.size() == 0) begin
      $error("unexpected result item: r_word=%h last_word=%b", got, got_last);
      errors++;
      return;
    end
    e = expected_words.pop_front();
    words_checked++;
    if (got !== e.value) begin
      $error("r_word mismatch: expected %h, actual %h", e.value, got);
      errors++;
    end
    if (got_last !== e.is_last) begin
      $error("last_word mismatch: expected %b, actual %b", e.is_last, got_last);
      errors++;
    end
  endtask

  // offer one item and wait for it to be taken
  task automatic send_word(logic op, logic [pfmas_pkg::WORD_W-1:0] x,
                           logic [pfmas_pkg::WORD_W-1:0] y);
    if (src_gap > 0) repeat (src_gap) @(posedge clk);
    in_valid <= 1'b1;
    req_type <= op;
    x_word   <= x;
    y_word   <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    src_gap = src_calm ? 0 : $urandom_range(0, 19);
    if (src_gap > 0) begin
      in_valid <= 1'b0;
      src_hold = 1'b0;
    end else begin
      src_hold = 1'b1;
    end
  endtask

  // drop valid if the last item left it high
  task automatic src_release();
    if (src_hold) begin
      in_valid <= 1'b0;
      src_hold = 1'b0;
    end
  endtask

  // one full operation, NUM_WORDS items
  task automatic send_operation(op_row_t row);
    logic op_bit;
    for (int i = 0; i < WORDS; i++) begin
      // req_type only counts on the first word
      op_bit = (row.flip && i != 0) ? ~row.op : row.op;
      send_word(op_bit, row.x[pfmas_pkg::WORD_W*i +: pfmas_pkg::WORD_W],
                row.y[pfmas_pkg::WORD_W*i +: pfmas_pkg::WORD_W]);
      if (addsub_word(op_bit, row.x[pfmas_pkg::WORD_W*i +: pfmas_pkg::WORD_W],
                      row.y[pfmas_pkg::WORD_W*i +: pfmas_pkg::WORD_W])) begin
        for (int k = 0; k < WORDS; k++) begin
          expected_words.push_back('{value: row.typed
                                       ? row.sum[pfmas_pkg::WORD_W*k +: pfmas_pkg::WORD_W]
                                       : fixed_words[k],
                                     is_last: (k == WORDS - 1)});
        end
      end
    end
    if (row.op == pfmas_pkg::OP_ADD) add_ops++;
    else sub_ops++;
  endtask

  // wait until every expected item has come, then let the block settle
  task automatic wait_drained();
    src_release();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [pfmas_pkg::CFG_IDX_W-1:0] idx,
                           logic [pfmas_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mod_reg[idx] = data;
  endtask

  task automatic write_modulus(logic [WIDE-1:0] m);
    write_reg(pfmas_pkg::REG_MOD_W0, m[63:0]);
    write_reg(pfmas_pkg::REG_MOD_W1, m[127:64]);
    write_reg(pfmas_pkg::REG_MOD_W2, m[191:128]);
    write_reg(pfmas_pkg::REG_MOD_W3, m[255:192]);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // result side: random stalls, a long hold on request
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int holds_done;
    stall_left = 0;
    hold_left  = 0;
    holds_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && !out_stall) begin
          check_word(r_word, last_word);
          stall_left = sink_calm ? 0 : $urandom_range(0, 19);
        end else if (stall_left > 0) begin
          stall_left--;
        end
        if (holds_done != hold_asks) begin
          holds_done = hold_asks;
          hold_left = LONG_HOLD;
        end else if (hold_left > 0) begin
          hold_left--;
        end
        out_stall <= (stall_left > 0) || (hold_left > 0);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    op_row_t         directed [3];
    op_row_t         row;
    logic [WIDE-1:0] m;
    errors = 0;
    words_checked = 0;
    add_ops = 0;
    sub_ops = 0;
    settings_used = 1;
    src_calm = 1'b0;
    sink_calm = 1'b0;
    hold_asks = 0;
    src_gap = 0;
    src_hold = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    req_type  <= pfmas_pkg::OP_ADD;
    x_word    <= '0;
    y_word    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= pfmas_pkg::REG_MOD_W0;
    cfg_data  <= '0;

    // predictor state after reset
    mod_reg[pfmas_pkg::REG_MOD_W0] = pfmas_pkg::MOD_W0_RST;
    mod_reg[pfmas_pkg::REG_MOD_W1] = pfmas_pkg::MOD_W1_RST;
    mod_reg[pfmas_pkg::REG_MOD_W2] = pfmas_pkg::MOD_W2_RST;
    mod_reg[pfmas_pkg::REG_MOD_W3] = pfmas_pkg::MOD_W3_RST;
    carry_run = 1'b0;
    cmp_run = pfmas_pkg::CMP_EQUAL;
    word_pos = 0;
    op_held = pfmas_pkg::OP_ADD;

    // directed operations under the reset modulus
    // all-ones operands: unreduced, carry out of the top word
    directed[0] = '{op: pfmas_pkg::OP_ADD, x: ALL_ONES, y: ALL_ONES, typed: 1'b0,
                    sum: '0, flip: 1'b0};
    // sum equals the modulus exactly, req_type toggled after the first word
    directed[1] = '{op: pfmas_pkg::OP_ADD, x: P256 - 1'b1, y: WIDE'(1), typed: 1'b1,
                    sum: '0, flip: 1'b1};
    // final borrow, modulus added back
    directed[2] = '{op: pfmas_pkg::OP_SUB, x: '0, y: WIDE'(1), typed: 1'b1,
                    sum: P256 - 1'b1, flip: 1'b0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_operation(directed[i]);

    // random phases, each after the first under a newly written modulus
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        wait_drained();
        case (ph)
          1: m = ALL_ONES;
          2: m = '0;
          3: m = random_wide(1'b0) | {1'b1, {(WIDE-1){1'b0}}};
          4: begin
            m = random_wide(1'b0);
            m = {{(WIDE-64){1'b0}}, m[63:0]};
          end
          5: m = random_wide(1'b1);
          default: m = P256;
        endcase
        write_modulus(m);
        repeat (2) @(posedge clk);
      end
      src_calm  = (ph == 1) || (ph == 3);
      sink_calm = (ph == 1) || (ph == 4);
      for (int n = 0; n < OPS_PER_PHASE; n++) begin
        // receiver holds off while items keep coming
        if (ph == 3 && n == 1) hold_asks++;
        // sender pauses until the block has drained
        if (ph == 5 && n == 2) begin
          src_release();
          while (expected_words.size() != 0) @(posedge clk);
        end
        m = modulus_now();
        row.op    = $urandom_range(0, 1) ? pfmas_pkg::OP_SUB : pfmas_pkg::OP_ADD;
        row.x     = pick_operand(m);
        row.y     = pick_operand(m);
        row.typed = 1'b0;
        row.sum   = '0;
        row.flip  = ($urandom_range(0, 7) == 0);
        send_operation(row);
      end
    end

    wait_drained();
    $display("covered %0d operations (%0d add, %0d subtract) under %0d modulus settings",
             add_ops + sub_ops, add_ops, sub_ops, settings_used);
    $display("%0d result words compared, %0d mismatches", words_checked, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
